// ===== rtl/core/msr_pkg.sv =====
// Shared types and constants for the multi-servo step ramp unit.
package msr_pkg;

    localparam int CHANNELS_DEF  = 5;
    localparam int TARGET_FIELDS = 5;
    localparam int ADDR_W        = 3;

    localparam logic [7:0] NO_MOVE    = 8'd255;
    localparam logic [7:0] HOME_ANGLE = 8'd90;
    localparam logic [1:0] STEP_RESET = 2'd2;
    localparam logic [8:0] DIV3_MUL   = 9'd171;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // paddr[2] selects the register
    localparam logic REG_STEP_ANGLE = 1'b0;

    localparam logic [1:0] SA_ZERO  = 2'd0;
    localparam logic [1:0] SA_ONE   = 2'd1;
    localparam logic [1:0] SA_TWO   = 2'd2;
    localparam logic [1:0] SA_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] cur;
        logic [7:0] steps;
        logic       down;
    } t_chan;

endpackage

// ===== rtl/core/multi_servo_step_ramp_unit.sv =====
// Top level: channel state, sequencer, output word register and APB register.
// A load or tick word steps through the channels one at a time via the shared unit,
// and a tick stalls on a moving channel while an output word waits.
// A new input word is taken only once the sequencer is back in idle.
// A write appears on the master side the cycle after its channel is stepped.
// Reset (synchronous, active low): angles 90, no steps pending, step_angle 2.
module multi_servo_step_ramp_unit #(
    parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [39:0]                i_s_tdata,   // target_angle_a..e, 8 bits each
    input  logic                       i_s_tuser,   // mode
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [15:0]                o_m_tdata,   // servo_index[2:0], new_angle[10:3]
    output logic                       o_m_tlast,   // last_of_round
    output logic                       o_m_tuser,   // move_done
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [msr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_TICK} t_state;

    t_state          r_state;
    logic [IW-1:0]   r_idx;
    logic [39:0]     r_tdata;
    logic            r_done;
    logic [1:0]      r_step_angle;
    logic [7:0]      r_cur   [CHANNELS];
    logic [7:0]      r_steps [CHANNELS];
    logic            r_down  [CHANNELS];
    logic            r_out_valid;
    logic [2:0]      r_out_idx;
    logic [7:0]      r_out_angle;
    logic            r_out_last;
    logic            r_out_done;

    msr_pkg::t_chan  w_ch_in;
    msr_pkg::t_chan  w_ch_out;
    logic [7:0]      w_tgt;
    logic            w_later;
    logic            w_all_le1;
    logic            w_moves;
    logic            w_out_free;
    logic            w_emit;
    logic            w_adv;
    logic            w_last_idx;
    logic            w_accept;
    logic [7:0]      w_idx8;

    assign w_ch_in.cur   = r_cur[r_idx];
    assign w_ch_in.steps = r_steps[r_idx];
    assign w_ch_in.down  = r_down[r_idx];

    always_comb begin
        w_tgt = msr_pkg::NO_MOVE;
        for (int k = 0; k < msr_pkg::TARGET_FIELDS; k++) begin
            if (k < CHANNELS && 32'(r_idx) == k) begin
                w_tgt = r_tdata[8*k +: 8];
            end
        end
    end

    always_comb begin
        w_later   = 1'b0;
        w_all_le1 = 1'b1;
        for (int k = 0; k < CHANNELS; k++) begin
            if (r_steps[k] != 8'd0 && k > 32'(r_idx)) begin
                w_later = 1'b1;
            end
            if (r_steps[k] > 8'd1) begin
                w_all_le1 = 1'b0;
            end
        end
    end

    msr_alu u_alu (
        .i_ch         (w_ch_in),
        .i_target     (w_tgt),
        .i_step_angle (r_step_angle),
        .i_load       (r_state == S_LOAD),
        .o_ch         (w_ch_out)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_moves    = w_ch_in.steps != 8'd0;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit     = (r_state == S_TICK) && w_moves && w_out_free;
    assign w_adv      = (r_state == S_LOAD) ||
                        ((r_state == S_TICK) && (!w_moves || w_out_free));
    assign w_last_idx = r_idx == IW'(CHANNELS - 1);
    assign w_idx8     = 8'(r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_cur[k]   <= msr_pkg::HOME_ANGLE;
                r_steps[k] <= 8'd0;
                r_down[k]  <= 1'b0;
            end
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept) begin
                        r_state <= (i_s_tuser == msr_pkg::MODE_TICK) ? S_TICK : S_LOAD;
                    end
                end
                S_LOAD, S_TICK: begin
                    if (w_adv) begin
                        r_cur[r_idx]   <= w_ch_out.cur;
                        r_steps[r_idx] <= w_ch_out.steps;
                        r_down[r_idx]  <= w_ch_out.down;
                        if (w_last_idx) begin
                            r_state <= S_IDLE;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tdata <= i_s_tdata;
            r_done  <= w_all_le1;
        end
        if (w_emit) begin
            r_out_idx   <= w_idx8[2:0];
            r_out_angle <= w_ch_out.cur;
            r_out_last  <= !w_later;
            r_out_done  <= !w_later && r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_angle <= msr_pkg::STEP_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == msr_pkg::REG_STEP_ANGLE) begin
            r_step_angle <= pwdata[1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == msr_pkg::REG_STEP_ANGLE) ? 32'(r_step_angle) : 32'd0;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_angle, r_out_idx};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_done;

endmodule

// ===== rtl/core/msr_alu.sv =====
// Shared per-channel unit: step count on load, one step of travel on tick.
module msr_alu (
    input  msr_pkg::t_chan i_ch,
    input  logic [7:0]     i_target,
    input  logic [1:0]     i_step_angle,
    input  logic           i_load,
    output msr_pkg::t_chan o_ch
);

    logic [7:0]  w_diff;
    logic        w_up;
    logic [16:0] w_prod;
    logic [7:0]  w_quot;
    logic [7:0]  w_sa8;

    assign w_up   = i_target > i_ch.cur;
    assign w_diff = w_up ? (i_target - i_ch.cur) : (i_ch.cur - i_target);
    assign w_prod = 17'(w_diff) * 17'(msr_pkg::DIV3_MUL);
    assign w_sa8  = 8'(i_step_angle);

    always_comb begin
        case (i_step_angle)
            msr_pkg::SA_ONE:   w_quot = w_diff;
            msr_pkg::SA_TWO:   w_quot = w_diff >> 1;
            msr_pkg::SA_THREE: w_quot = w_prod[16:9];
            default:           w_quot = 8'd0;
        endcase
    end

    always_comb begin
        o_ch = i_ch;
        if (i_load) begin
            o_ch.down = !w_up;
            if (i_target == msr_pkg::NO_MOVE || i_step_angle == msr_pkg::SA_ZERO) begin
                o_ch.steps = 8'd0;
            end else begin
                o_ch.steps = w_quot;
            end
        end else if (i_ch.steps != 8'd0) begin
            o_ch.cur   = i_ch.down ? (i_ch.cur - w_sa8) : (i_ch.cur + w_sa8);
            o_ch.steps = i_ch.steps - 8'd1;
        end
    end

endmodule

// ===== rtl/core/msr_checker.sv =====
// Port-level assertions for the multi-servo step ramp unit, bound to the top level.
module msr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       i_s_tuser,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [15:0]                o_m_tdata,
    input logic                       o_m_tlast,
    input logic                       o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
        && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output word changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("move_done on a word that is not last of round");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready right after an accepted word");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[2:0] <= 3'd4 && o_m_tdata[15:11] == 5'd0)
        else $error("servo index out of range or padding set");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == msr_pkg::MODE_LOAD && !o_m_tvalid
        |=> !o_m_tvalid)
        else $error("write produced by a load word");

endmodule

bind multi_servo_step_ramp_unit msr_checker u_msr_checker (.*);
